// ===== rtl/lcadc_pkg.sv =====
// shared types and constants for the load cell adc reader
package lcadc_pkg;

  localparam int DATA_BITS_DEF = 24;
  localparam int RAW_W         = 25;
  localparam int WEIGHT_W      = 32;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 32;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_PULSES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_TICKS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POLL_PERIOD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET      = 3'd5;

  // gain select codes (extra pulses after the data bits)
  localparam logic [1:0] GAIN128 = 2'd1;
  localparam logic [1:0] GAIN64  = 2'd3;
  localparam logic [1:0] GAIN32  = 2'd2;

  localparam logic        RST_ENABLE      = 1'b1;
  localparam logic [1:0]  RST_GAIN_PULSES = GAIN128;
  localparam logic [7:0]  RST_HALF_TICKS  = 8'd50;
  localparam logic [23:0] RST_POLL_PERIOD = 24'd500000;
  localparam logic signed [31:0] RST_SCALE  = 32'sd181614;
  localparam logic signed [31:0] RST_OFFSET = -32'sd1453488;

  typedef struct packed {
    logic        enable;
    logic [1:0]  gain_pulses;
    logic [7:0]  half_bit_ticks;
    logic [23:0] poll_period_ticks;
  } ctrl_cfg_t;

  typedef struct packed {
    logic serial_clock;
    logic sample_valid;
  } step_t;

endpackage

// ===== rtl/lcadc_in_if.sv =====
// tick channel carrying the sampled data pin
interface lcadc_in_if;
  logic valid;
  logic ready;
  logic data_in;

  modport source (output valid, output data_in, input ready);
  modport sink (input valid, input data_in, output ready);
endinterface

// ===== rtl/lcadc_out_if.sv =====
// result channel: clock level, completion flag and held readings
interface lcadc_out_if;
  logic                                valid;
  logic                                ready;
  logic                                serial_clock;
  logic                                sample_valid;
  logic signed [lcadc_pkg::RAW_W-1:0]    raw_reading;
  logic signed [lcadc_pkg::WEIGHT_W-1:0] weight_q16;

  modport source (output valid, output serial_clock, output sample_valid,
                  output raw_reading, output weight_q16, input ready);
  modport sink (input valid, input serial_clock, input sample_valid,
                input raw_reading, input weight_q16, output ready);
endinterface

// ===== rtl/lcadc_cfg_if.sv =====
// register write channel
interface lcadc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [lcadc_pkg::CFG_IDX_W-1:0]   index;
  logic [lcadc_pkg::CFG_DATA_W-1:0]  wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

// ===== rtl/lcadc_ctrl.sv =====
// poll timer and serial clock sequencer, one step per accepted tick
module lcadc_ctrl #(
  parameter int DATA_BITS = lcadc_pkg::DATA_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step_i,
  input  logic                   data_i,
  input  lcadc_pkg::ctrl_cfg_t   cfg_i,
  output lcadc_pkg::step_t       res_o,
  output logic signed [DATA_BITS:0] raw_o
);
  import lcadc_pkg::*;

  localparam int PCW = $clog2(DATA_BITS + 1);

  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_DATA_HIGH = 3'd1;
  localparam logic [2:0] PH_DATA_LOW  = 3'd2;
  localparam logic [2:0] PH_GAIN_HIGH = 3'd3;
  localparam logic [2:0] PH_GAIN_LOW  = 3'd4;

  logic [2:0]       phase_r, phase_nxt;
  logic [PCW-1:0]   pc_r, pc_nxt;
  logic [7:0]       htc_r, htc_nxt;
  logic [23:0]      poll_r, poll_nxt;
  logic [DATA_BITS:0] shift_r, shift_nxt;

  logic [23:0]  period;
  logic [7:0]   half;
  logic [24:0]  poll_inc;
  logic         poll;
  logic [8:0]   htc_inc;
  logic         half_done;
  logic [PCW:0] pc_inc;
  logic         clk_lvl;
  logic         done;

  always_comb begin
    period    = (cfg_i.poll_period_ticks == '0) ? 24'd1 : cfg_i.poll_period_ticks;
    half      = (cfg_i.half_bit_ticks == '0) ? 8'd1 : cfg_i.half_bit_ticks;
    poll_inc  = {1'b0, poll_r} + 25'd1;
    poll      = poll_inc >= {1'b0, period};
    poll_nxt  = poll ? '0 : poll_inc[23:0];
    htc_inc   = {1'b0, htc_r} + 9'd1;
    half_done = htc_inc >= {1'b0, half};
    pc_inc    = {1'b0, pc_r} + (PCW+1)'(1);

    phase_nxt = phase_r;
    pc_nxt    = pc_r;
    htc_nxt   = htc_r;
    shift_nxt = shift_r;
    clk_lvl   = 1'b0;
    done      = 1'b0;

    if (phase_r == PH_IDLE) begin
      if (poll && cfg_i.enable && !data_i) begin
        phase_nxt = PH_DATA_HIGH;
        htc_nxt   = '0;
        pc_nxt    = '0;
        shift_nxt = '0;
      end
    end else begin
      clk_lvl = (phase_r == PH_DATA_HIGH) || (phase_r == PH_GAIN_HIGH);
      htc_nxt = htc_inc[7:0];
      if (half_done) begin
        htc_nxt = '0;
        case (phase_r)
          PH_DATA_HIGH: begin
            // first bit lands at the top, msb first
            for (int i = 1; i <= DATA_BITS; i++) begin
              if ({1'b0, pc_r} == (PCW+1)'(DATA_BITS - i)) begin
                shift_nxt[i] = shift_r[i] | data_i;
              end
            end
            phase_nxt = PH_DATA_LOW;
          end
          PH_DATA_LOW: begin
            pc_nxt = pc_inc[PCW-1:0];
            if (pc_inc >= (PCW+1)'(DATA_BITS)) begin
              pc_nxt = '0;
              if (cfg_i.gain_pulses == '0) begin
                done      = 1'b1;
                phase_nxt = PH_IDLE;
              end else begin
                phase_nxt = PH_GAIN_HIGH;
              end
            end else begin
              phase_nxt = PH_DATA_HIGH;
            end
          end
          PH_GAIN_HIGH: begin
            phase_nxt = PH_GAIN_LOW;
          end
          PH_GAIN_LOW: begin
            pc_nxt = pc_inc[PCW-1:0];
            if (pc_inc >= (PCW+1)'(cfg_i.gain_pulses)) begin
              done      = 1'b1;
              phase_nxt = PH_IDLE;
            end else begin
              phase_nxt = PH_GAIN_HIGH;
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      pc_r    <= '0;
      htc_r   <= '0;
      poll_r  <= '0;
      shift_r <= '0;
    end else if (step_i) begin
      phase_r <= phase_nxt;
      pc_r    <= pc_nxt;
      htc_r   <= htc_nxt;
      poll_r  <= poll_nxt;
      shift_r <= shift_nxt;
    end
  end

  // a read never ends on a tick that shifts in a bit, so the stored word is final
  assign res_o.serial_clock = clk_lvl;
  assign res_o.sample_valid = done;
  assign raw_o              = $signed(shift_r);

endmodule

// ===== rtl/load_cell_adc_reader.sv =====
// load cell adc reader top level: registers, sequencer and weight pipeline
// Every accepted tick on in_ch gives exactly one result on out_ch, one tick per
// clock cycle sustained while out_ch is ready; a tick passes the sequencer step,
// the multiply stage and the round and saturate stage into the output register,
// and a full stage holds while the next one cannot take its contents, so the
// stages back up when out_ch is not ready. Serial timing is counted in ticks:
// a read lasts 2 * half_bit_ticks * (DATA_BITS + gain_pulses) ticks after the
// poll that finds data low, and sample_valid marks the tick whose result
// carries the new raw_reading and weight_q16. Register writes take effect at
// once and are meant to be made while no tick is in flight.
module load_cell_adc_reader #(
  parameter int DATA_BITS = lcadc_pkg::DATA_BITS_DEF
) (
  input logic           clk,
  input logic           rst_n,
  lcadc_in_if.sink      in_ch,
  lcadc_out_if.source   out_ch,
  lcadc_cfg_if.sink     cfg_ch
);
  import lcadc_pkg::*;

  localparam int RW  = DATA_BITS + 1;
  localparam int RXW = (RW > RAW_W) ? RW : RAW_W;
  localparam int PW  = 32 + RW;
  localparam int QW  = PW - 16;
  localparam int SW  = QW + 2;

  // configuration registers
  ctrl_cfg_t             cfg_r;
  logic signed [31:0]    scale_r;
  logic signed [31:0]    offset_r;
  logic                  cfg_xfer;

  assign cfg_ch.ready = 1'b1;
  assign cfg_xfer     = cfg_ch.valid && cfg_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable            <= RST_ENABLE;
      cfg_r.gain_pulses       <= RST_GAIN_PULSES;
      cfg_r.half_bit_ticks    <= RST_HALF_TICKS;
      cfg_r.poll_period_ticks <= RST_POLL_PERIOD;
      scale_r                 <= RST_SCALE;
      offset_r                <= RST_OFFSET;
    end else if (cfg_xfer) begin
      case (cfg_ch.index)
        REG_ENABLE:      cfg_r.enable            <= cfg_ch.wdata[0];
        REG_GAIN_PULSES: cfg_r.gain_pulses       <= cfg_ch.wdata[1:0];
        REG_HALF_TICKS:  cfg_r.half_bit_ticks    <= cfg_ch.wdata[7:0];
        REG_POLL_PERIOD: cfg_r.poll_period_ticks <= cfg_ch.wdata[23:0];
        REG_SCALE:       scale_r                 <= $signed(cfg_ch.wdata);
        REG_OFFSET:      offset_r                <= $signed(cfg_ch.wdata);
        default: begin
        end
      endcase
    end
  end

  // pipeline handshake
  logic s1_v_r, s2_v_r, s3_v_r;
  logic ready1, ready2, ready3;
  logic load1, load2, load3;

  assign ready3 = !s3_v_r || out_ch.ready;
  assign ready2 = !s2_v_r || ready3;
  assign ready1 = !s1_v_r || ready2;
  assign load1  = in_ch.valid && ready1;
  assign load2  = s1_v_r && ready2;
  assign load3  = s2_v_r && ready3;
  assign in_ch.ready = ready1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= load1 || (s1_v_r && !ready2);
      s2_v_r <= load2 || (s2_v_r && !ready3);
      s3_v_r <= load3 || (s3_v_r && !out_ch.ready);
    end
  end

  // stage 1: sequencer step
  step_t                 step;
  logic signed [RW-1:0]  raw;
  step_t                 s1_step_r;
  logic signed [RW-1:0]  s1_raw_r;

  lcadc_ctrl #(
    .DATA_BITS (DATA_BITS)
  ) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_i (load1),
    .data_i (in_ch.data_in),
    .cfg_i  (cfg_r),
    .res_o  (step),
    .raw_o  (raw)
  );

  always_ff @(posedge clk) begin
    if (load1) begin
      s1_step_r <= step;
      s1_raw_r  <= raw;
    end
  end

  // stage 2: scale times raw
  step_t                 s2_step_r;
  logic signed [RW-1:0]  s2_raw_r;
  logic signed [PW-1:0]  s2_prod_r;

  always_ff @(posedge clk) begin
    if (load2) begin
      s2_step_r <= s1_step_r;
      s2_raw_r  <= s1_raw_r;
      s2_prod_r <= PW'(scale_r) * PW'(s1_raw_r);
    end
  end

  // stage 3: round to nearest, add intercept, saturate; held in the output register
  function automatic logic signed [31:0] round_sat(input logic signed [PW-1:0] prod,
                                                   input logic signed [31:0] ofs);
    logic signed [QW-1:0] q;
    logic signed [SW-1:0] sum;
    logic                 ovf;
    q   = QW'(prod >>> 16);
    sum = SW'(q) + SW'({1'b0, prod[15]}) + SW'(ofs);
    ovf = (sum[SW-1:31] != '0) && (sum[SW-1:31] != '1);
    if (!ovf) begin
      round_sat = sum[31:0];
    end else if (sum[SW-1]) begin
      round_sat = 32'sh8000_0000;
    end else begin
      round_sat = 32'sh7FFF_FFFF;
    end
  endfunction

  logic                       out_clk_r;
  logic                       out_done_r;
  logic signed [RAW_W-1:0]    raw_r;
  logic signed [WEIGHT_W-1:0] weight_r;
  logic signed [RXW-1:0]      s2_raw_x;

  assign s2_raw_x = RXW'(s2_raw_r);

  always_ff @(posedge clk) begin
    if (load3) begin
      out_clk_r  <= s2_step_r.serial_clock;
      out_done_r <= s2_step_r.sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r    <= '0;
      weight_r <= '0;
    end else if (load3 && s2_step_r.sample_valid) begin
      raw_r    <= s2_raw_x[RAW_W-1:0];
      weight_r <= round_sat(s2_prod_r, offset_r);
    end
  end

  assign out_ch.valid        = s3_v_r;
  assign out_ch.serial_clock = out_clk_r;
  assign out_ch.sample_valid = out_done_r;
  assign out_ch.raw_reading  = raw_r;
  assign out_ch.weight_q16   = weight_r;

endmodule

// ===== verif/tb_load_cell_adc_reader.sv =====
// testbench for the load cell adc reader: per-tick prediction of clock, completion and readings
module tb_load_cell_adc_reader;
  timeunit 1ns;
  timeprecision 1ps;

  import lcadc_pkg::*;

  localparam int DATA_BITS    = DATA_BITS_DEF;
  localparam int PIPE_SETTLE  = 4;
  localparam int RANDOM_TICKS = 350;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = REG_OFFSET + 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = '1;
  localparam logic [1:0] NO_GAIN_PULSES = 2'd0;

  typedef enum logic [2:0] {
    RD_IDLE, RD_DATA_HIGH, RD_DATA_LOW, RD_GAIN_HIGH, RD_GAIN_LOW
  } rd_phase_t;

  typedef enum int {DM_WORD, DM_WELL_FORMED, DM_NOISE, DM_BUSY} data_mode_t;
  typedef enum int {RX_FREE, RX_COIN, RX_PERIODIC, RX_LONG} rx_mode_t;

  typedef struct {
    logic                       serial_clock;
    logic                       sample_valid;
    logic signed [RAW_W-1:0]    raw;
    logic signed [WEIGHT_W-1:0] weight;
  } tick_result_t;

  typedef struct {
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
  } reg_write_t;

  logic clk = 1'b0;
  logic rst_n;

  lcadc_in_if  in_ch();
  lcadc_out_if out_ch();
  lcadc_cfg_if cfg_ch();

  load_cell_adc_reader i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #4 clk = ~clk;

  // register shadow
  logic                 cf_enable;
  logic [1:0]           cf_gain;
  logic [7:0]           cf_half;
  logic [23:0]          cf_period;
  logic signed [31:0]   cf_scale;
  logic signed [31:0]   cf_offset;

  // reader state
  rd_phase_t                  rd_phase;
  int unsigned                bit_count;
  int unsigned                half_count;
  int unsigned                poll_cnt;
  logic [DATA_BITS:0]         shift_word;
  logic signed [DATA_BITS:0]  held_raw;
  logic signed [31:0]         held_weight;

  tick_result_t expected_q[$];
  reg_write_t   pending_q[$];
  int errors      = 0;
  int reads_done  = 0;
  int burst_left  = 0;

  task automatic reset_model();
    cf_enable   = RST_ENABLE;
    cf_gain     = RST_GAIN_PULSES;
    cf_half     = RST_HALF_TICKS;
    cf_period   = RST_POLL_PERIOD;
    cf_scale    = RST_SCALE;
    cf_offset   = RST_OFFSET;
    rd_phase    = RD_IDLE;
    bit_count   = 0;
    half_count  = 0;
    poll_cnt    = 0;
    shift_word  = '0;
    held_raw    = '0;
    held_weight = '0;
  endtask

  task automatic write_shadow(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_ENABLE:      cf_enable = val[0];
      REG_GAIN_PULSES: cf_gain   = val[1:0];
      REG_HALF_TICKS:  cf_half   = val[7:0];
      REG_POLL_PERIOD: cf_period = val[23:0];
      REG_SCALE:       cf_scale  = val;
      REG_OFFSET:      cf_offset = val;
      default: ;
    endcase
  endtask

  // scale * raw / 2^16, rounded half up, plus offset, saturated
  function automatic logic signed [31:0] calibrate(logic signed [DATA_BITS:0] raw);
    longint prod;
    longint acc;
    prod = longint'(cf_scale) * longint'(raw);
    acc  = (prod >>> 16) + ((prod >> 15) & 64'sd1) + longint'(cf_offset);
    if (acc > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (acc < -64'sd2147483648) return 32'sh8000_0000;
    return acc[31:0];
  endfunction

  task automatic latch_reading();
    held_raw    = $signed(shift_word);
    held_weight = calibrate(held_raw);
    rd_phase    = RD_IDLE;
  endtask

  task automatic predict_tick(logic d);
    tick_result_t r;
    int unsigned  period;
    int unsigned  half;
    logic         poll;
    period = (cf_period == 0) ? 1 : cf_period;
    half   = (cf_half == 0) ? 1 : cf_half;
    r.serial_clock = 1'b0;
    r.sample_valid = 1'b0;
    if (poll_cnt + 1 >= period) begin
      poll     = 1'b1;
      poll_cnt = 0;
    end else begin
      poll     = 1'b0;
      poll_cnt = poll_cnt + 1;
    end
    if (rd_phase == RD_IDLE) begin
      if (poll && cf_enable && !d) begin
        rd_phase   = RD_DATA_HIGH;
        half_count = 0;
        bit_count  = 0;
        shift_word = '0;
      end
    end else begin
      r.serial_clock = (rd_phase == RD_DATA_HIGH || rd_phase == RD_GAIN_HIGH);
      half_count++;
      if (half_count >= half) begin
        half_count = 0;
        case (rd_phase)
          RD_DATA_HIGH: begin
            // msb first, landing one bit above its natural position
            if (bit_count < DATA_BITS && d) shift_word[DATA_BITS - bit_count] = 1'b1;
            rd_phase = RD_DATA_LOW;
          end
          RD_DATA_LOW: begin
            bit_count++;
            if (bit_count >= DATA_BITS) begin
              bit_count = 0;
              if (cf_gain == NO_GAIN_PULSES) begin
                latch_reading();
                r.sample_valid = 1'b1;
              end else begin
                rd_phase = RD_GAIN_HIGH;
              end
            end else begin
              rd_phase = RD_DATA_HIGH;
            end
          end
          RD_GAIN_HIGH: rd_phase = RD_GAIN_LOW;
          default: begin
            bit_count++;
            if (bit_count >= cf_gain) begin
              latch_reading();
              r.sample_valid = 1'b1;
            end else begin
              rd_phase = RD_GAIN_HIGH;
            end
          end
        endcase
      end
    end
    r.raw    = held_raw;
    r.weight = held_weight;
    expected_q.push_back(r);
    if (r.sample_valid) reads_done++;
  endtask

  function automatic logic pick_data(data_mode_t m, logic [DATA_BITS-1:0] word);
    case (m)
      DM_WORD: begin
        if ((rd_phase == RD_DATA_HIGH || rd_phase == RD_DATA_LOW) && bit_count < DATA_BITS)
          return word[DATA_BITS - 1 - bit_count];
        else
          return 1'b0;
      end
      // mostly ready at poll time, random bits once a read runs
      DM_WELL_FORMED: return (rd_phase == RD_IDLE) ? ($urandom_range(0, 9) == 0)
                                                   : 1'($urandom_range(0, 1));
      DM_BUSY: return 1'b1;
      default: return 1'($urandom_range(0, 1));
    endcase
  endfunction

  task automatic send_tick(logic d);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 200) : $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid   <= 1'b1;
    in_ch.data_in <= d;
    do @(posedge clk); while (!in_ch.ready);
    predict_tick(d);
  endtask

  task automatic run_ticks(int n, data_mode_t m, logic [DATA_BITS-1:0] word);
    repeat (n) send_tick(pick_data(m, word));
  endtask

  task automatic run_read(logic [DATA_BITS-1:0] word);
    int start;
    start = reads_done;
    while (reads_done == start) send_tick(pick_data(DM_WORD, word));
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  task automatic queue_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    reg_write_t w;
    w.idx = idx;
    w.val = val;
    pending_q.push_back(w);
  endtask

  // writes go out back to back once no tick is in flight
  task automatic apply_cfg();
    reg_write_t w;
    drain_results();
    if (pending_q.size() == 0) return;
    while (pending_q.size() != 0) begin
      w = pending_q.pop_front();
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= w.idx;
      cfg_ch.wdata <= w.val;
      do @(posedge clk); while (!cfg_ch.ready);
      write_shadow(w.idx, w.val);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic read_case(logic [1:0] gain, logic [7:0] half, logic [31:0] scale,
                           logic [31:0] offset, logic [DATA_BITS-1:0] word);
    queue_reg(REG_GAIN_PULSES, 32'(gain));
    queue_reg(REG_HALF_TICKS, 32'(half));
    queue_reg(REG_SCALE, scale);
    queue_reg(REG_OFFSET, offset);
    apply_cfg();
    run_read(word);
  endtask

  task automatic test_reset_state();
    run_ticks(8, DM_NOISE, '0);
  endtask

  // sign and saturation corners, rounding ties, zero half and zero gain pulses
  task automatic test_read_extremes();
    queue_reg(REG_ENABLE, 32'd1);
    queue_reg(REG_POLL_PERIOD, 32'd0);
    read_case(GAIN128, 8'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'h7FFFFF);
    read_case(GAIN64, 8'd1, 32'h7FFF_FFFF, 32'h8000_0000, 24'h800000);
    read_case(GAIN32, 8'd1, 32'h8000_0000, 32'h0000_0000, 24'h800000);
    read_case(NO_GAIN_PULSES, 8'd1, 32'h8000_0000, 32'h8000_0000, 24'h7FFFFF);
    read_case(GAIN128, 8'd1, 32'h0000_4000, 32'h0000_0000, 24'h000001);
    read_case(GAIN128, 8'd1, 32'h0000_4000, 32'h0000_0000, 24'hFFFFFF);
    read_case(GAIN64, 8'd2, RST_SCALE, RST_OFFSET, 24'h000000);
    read_case(GAIN32, 8'd1, RST_SCALE, RST_OFFSET, 24'h123456);
  endtask

  task automatic test_enable_gate();
    queue_reg(REG_ENABLE, 32'hFFFF_FFFE);
    queue_reg(REG_GAIN_PULSES, 32'(GAIN128));
    queue_reg(REG_HALF_TICKS, 32'hFFFF_FF01);
    queue_reg(REG_POLL_PERIOD, 32'd3);
    queue_reg(REG_SPARE_A, 32'hFFFF_FFFF);
    queue_reg(REG_SPARE_B, 32'h0000_0000);
    apply_cfg();
    run_ticks(40, DM_WORD, '0);
    queue_reg(REG_ENABLE, 32'hFFFF_FFFF);
    apply_cfg();
    run_ticks(30, DM_WORD, 24'h5A5A5A);
    // disable mid-read, the read must still finish
    queue_reg(REG_ENABLE, 32'd0);
    apply_cfg();
    run_read(24'h5A5A5A);
    run_ticks(20, DM_WORD, '0);
    queue_reg(REG_ENABLE, 32'd1);
    apply_cfg();
    run_ticks(30, DM_BUSY, '0);
  endtask

  task automatic test_midread_changes();
    queue_reg(REG_POLL_PERIOD, 32'h00FF_FFFF);
    queue_reg(REG_HALF_TICKS, 32'd255);
    queue_reg(REG_GAIN_PULSES, 32'(GAIN64));
    apply_cfg();
    run_ticks(20, DM_WORD, '0);
    // shrinking the period below the count polls at once
    queue_reg(REG_POLL_PERIOD, 32'd2);
    apply_cfg();
    run_ticks(100, DM_WORD, 24'hA5C3E1);
    queue_reg(REG_HALF_TICKS, 32'd3);
    queue_reg(REG_GAIN_PULSES, 32'(GAIN32));
    queue_reg(REG_SCALE, 32'hFFFF_0001);
    apply_cfg();
    run_read(24'hA5C3E1);
    // cut the gain stage short while the second gain pulse is high
    queue_reg(REG_HALF_TICKS, 32'd1);
    queue_reg(REG_GAIN_PULSES, 32'(GAIN64));
    queue_reg(REG_POLL_PERIOD, 32'd0);
    apply_cfg();
    run_ticks(52, DM_WORD, 24'h3C3C3C);
    queue_reg(REG_GAIN_PULSES, 32'(GAIN128));
    apply_cfg();
    run_read(24'h3C3C3C);
  endtask

  function automatic logic [31:0] pick_coeff();
    case ($urandom_range(0, 4))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 400000);
      3: return -$urandom_range(0, 2000000);
      default: return $urandom();
    endcase
  endfunction

  task automatic test_random_traffic();
    int          total;
    int          n;
    logic [31:0] v;
    data_mode_t  m;
    total = 0;
    while (total < RANDOM_TICKS) begin
      v = $urandom() & ~32'd1;
      queue_reg(REG_ENABLE, v | ($urandom_range(0, 7) != 0));
      if ($urandom_range(0, 1)) queue_reg(REG_GAIN_PULSES, $urandom());
      if ($urandom_range(0, 1)) begin
        v = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 20) : $urandom_range(0, 3);
        queue_reg(REG_HALF_TICKS, ($urandom() & 32'hFFFF_FF00) | v);
      end
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 11))
          0:       v = 32'h00FF_FFFF;
          1, 2, 3: v = $urandom_range(5, 80);
          default: v = $urandom_range(0, 4);
        endcase
        queue_reg(REG_POLL_PERIOD, ($urandom() & 32'hFF00_0000) | v);
      end
      if ($urandom_range(0, 2) != 0) queue_reg(REG_SCALE, pick_coeff());
      if ($urandom_range(0, 2) != 0) queue_reg(REG_OFFSET, pick_coeff());
      if ($urandom_range(0, 9) == 0)
        queue_reg(CFG_IDX_W'($urandom_range(REG_SPARE_A, REG_SPARE_B)), $urandom());
      apply_cfg();
      n = $urandom_range(60, 200);
      m = ($urandom_range(0, 19) < 17) ? DM_WELL_FORMED : DM_NOISE;
      run_ticks(n, m, '0);
      total += n;
    end
  endtask

  // receiver stall pattern
  initial begin
    int       cyc;
    int       hold;
    rx_mode_t mode;
    cyc  = 0;
    hold = 0;
    mode = RX_FREE;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 300 == 0) mode = rx_mode_t'($urandom_range(0, 3));
      case (mode)
        RX_FREE:     out_ch.ready <= 1'b1;
        RX_COIN:     out_ch.ready <= 1'($urandom_range(0, 1));
        RX_PERIODIC: out_ch.ready <= (cyc % 5) != 0;
        default: begin
          if (hold > 0) begin
            hold--;
            out_ch.ready <= 1'b0;
          end else if ($urandom_range(0, 15) == 0) begin
            hold = $urandom_range(1, 12);
            out_ch.ready <= 1'b0;
          end else begin
            out_ch.ready <= 1'b1;
          end
        end
      endcase
    end
  end

  task automatic flag_field(string name, logic signed [63:0] want, logic signed [63:0] got);
    errors++;
    $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
  endtask

  always @(posedge clk) begin : check_results
    tick_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t unexpected transfer: expected none, actual clk %0b done %0b raw %0d wt %0d",
                 $time, out_ch.serial_clock, out_ch.sample_valid, out_ch.raw_reading,
                 out_ch.weight_q16);
      end else begin
        want = expected_q.pop_front();
        if (out_ch.serial_clock !== want.serial_clock)
          flag_field("serial_clock", 64'(want.serial_clock), 64'(out_ch.serial_clock));
        if (out_ch.sample_valid !== want.sample_valid)
          flag_field("sample_valid", 64'(want.sample_valid), 64'(out_ch.sample_valid));
        if (out_ch.raw_reading !== want.raw)
          flag_field("raw_reading", 64'(want.raw), 64'(out_ch.raw_reading));
        if (out_ch.weight_q16 !== want.weight)
          flag_field("weight_q16", 64'(want.weight), 64'(out_ch.weight_q16));
      end
    end
  end

  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.data_in <= 1'b0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.index  <= REG_ENABLE;
    cfg_ch.wdata  <= '0;
    reset_model();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_read_extremes();
    test_enable_gate();
    test_midread_changes();
    test_random_traffic();
    drain_results();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/lcadc_pkg.sv
rtl/lcadc_in_if.sv
rtl/lcadc_out_if.sv
rtl/lcadc_cfg_if.sv
rtl/lcadc_ctrl.sv
rtl/load_cell_adc_reader.sv
verif/tb_load_cell_adc_reader.sv
